// ----- design/vector4_alu_core_defines.svh -----
// assertion macros for the vector4 alu core
// needs clk and rst_n in the scope of the module that uses them
`ifndef VECTOR4_ALU_CORE_DEFINES_SVH
`define VECTOR4_ALU_CORE_DEFINES_SVH

// condition holds at every edge out of reset
`define V4A_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define V4A_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define V4A_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/v4alu_pkg.sv -----
// shared types, constants and helpers of the vector4 alu core
// no dependencies
package v4alu_pkg;

  localparam int unsigned LANES      = 4;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned ROOT_W     = SQRT_STEPS;
  localparam int unsigned DIV_STEPS  = 48;
  localparam int unsigned NUM_W      = DIV_STEPS;
  localparam int unsigned DEN_W      = 33;
  localparam int unsigned REM_W      = DEN_W + 1;

  localparam logic [31:0] Q_MAX    = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN    = 32'h8000_0000;
  localparam logic [31:0] ONE_Q16  = 32'h0001_0000;
  localparam logic [15:0] TOL_RST  = 16'd7;

  localparam logic signed [65:0] CLIP_HI = 66'sd2147483647;
  localparam logic signed [65:0] CLIP_LO = -66'sd2147483648;

  typedef enum logic [3:0] {
    MODE_ADD    = 4'd0,
    MODE_SUB    = 4'd1,
    MODE_NEG    = 4'd2,
    MODE_SCALE  = 4'd3,
    MODE_DIV    = 4'd4,
    MODE_DOT    = 4'd5,
    MODE_CROSS  = 4'd6,
    MODE_MAG    = 4'd7,
    MODE_NORM   = 4'd8,
    MODE_REFL   = 4'd9,
    MODE_EQUAL  = 4'd10
  } mode_t;

  // per-item context carried down the pipeline
  typedef struct packed {
    mode_t                   mode;
    logic                    a_point;
    logic                    a_vector;
    logic [LANES-1:0][31:0]  a;
    logic [31:0]             f;
    logic [LANES-1:0][31:0]  r;
    logic [31:0]             scal;
    logic                    same;
    logic                    zdiv;
    logic                    sat;
  } ctx_t;

  // {clipped flag, q16.16 value}
  function automatic logic [32:0] clip_q(input logic signed [65:0] v);
    logic [32:0] res;
    if (v > CLIP_HI) begin
      res = {1'b1, Q_MAX};
    end else if (v < CLIP_LO) begin
      res = {1'b1, Q_MIN};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

endpackage

// ----- design/vector4_alu_core.sv -----
// vector4 alu core: pipelined q16.16 four-component vector unit
// depends on v4alu_pkg and vector4_alu_core_defines.svh
//
// channel  dir  handshake              payload
// in_      in   in_tvalid/in_tready    tdata ax..bw,factor; tuser mode
// out_     out  out_tvalid/out_tready  tdata rx..rw,scalar_out; tuser flags
// cfg_     in   cfg_valid/cfg_ready    cfg_data equal_tolerance
//
// one item per cycle while the pipeline advances; an item passes 87 register
// stages: 5 front stages, 32 square root steps, one setup stage, 48 divide
// steps and the output register
// the whole pipeline advances when the output register is empty or taken
// rst_n is synchronous, clears valid bits and loads the tolerance with 7
`include "vector4_alu_core_defines.svh"

module vector4_alu_core import v4alu_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [287:0] in_tdata,   // ax, ay, az, aw, bx, by, bz, bw, factor
  input  logic [3:0]   in_tuser,   // mode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata,  // rx, ry, rz, rw, scalar_out
  output logic [4:0]   out_tuser,  // same, a_is_point, a_is_vector, zero_divide, saturated
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data
);

  logic        adv;
  logic        out_tvalid_r;
  logic [15:0] tol_r;

  // global advance: every stage moves together
  assign adv       = !out_tvalid_r || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RST;
    end else if (cfg_valid) begin
      tol_r <= cfg_data;
    end
  end

  // ---------------- stage 1: input register
  logic                   v1_r;
  mode_t                  mode1_r;
  logic [LANES-1:0][31:0] a1_r, b1_r;
  logic [31:0]            f1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode1_r <= mode_t'(in_tuser);
      for (int i = 0; i < LANES; i++) begin
        a1_r[i] <= in_tdata[32*i +: 32];
        b1_r[i] <= in_tdata[128 + 32*i +: 32];
      end
      f1_r <= in_tdata[256 +: 32];
    end
  end

  // ---------------- stage 2: elementwise ops and the lane and cross products
  ctx_t               ctx2_nxt, ctx2_r;
  logic               v2_r;
  logic signed [31:0] op2 [LANES];
  logic signed [63:0] p2_nxt [LANES];
  logic signed [63:0] p2_r [LANES];
  logic signed [63:0] cx2_nxt [6];
  logic signed [63:0] cx2_r [6];
  logic [LANES-1:0][31:0] b2_r;

  always_comb begin
    logic [32:0]        tmp;
    logic signed [32:0] d;
    logic [32:0]        dabs;
    ctx2_nxt          = '0;
    ctx2_nxt.mode     = mode1_r;
    ctx2_nxt.a        = a1_r;
    ctx2_nxt.f        = f1_r;
    ctx2_nxt.a_point  = (a1_r[3] == ONE_Q16);
    ctx2_nxt.a_vector = (a1_r[3] == 32'd0);
    tmp  = '0;
    d    = '0;
    dabs = '0;
    case (mode1_r)
      MODE_ADD: begin
        for (int i = 0; i < LANES; i++) begin
          tmp = clip_q(66'($signed(a1_r[i])) + 66'($signed(b1_r[i])));
          ctx2_nxt.r[i] = tmp[31:0];
          ctx2_nxt.sat  = ctx2_nxt.sat | tmp[32];
        end
      end
      MODE_SUB: begin
        for (int i = 0; i < LANES; i++) begin
          tmp = clip_q(66'($signed(a1_r[i])) - 66'($signed(b1_r[i])));
          ctx2_nxt.r[i] = tmp[31:0];
          ctx2_nxt.sat  = ctx2_nxt.sat | tmp[32];
        end
      end
      MODE_NEG: begin
        for (int i = 0; i < LANES; i++) begin
          tmp = clip_q(-66'($signed(a1_r[i])));
          ctx2_nxt.r[i] = tmp[31:0];
          ctx2_nxt.sat  = ctx2_nxt.sat | tmp[32];
        end
      end
      MODE_EQUAL: begin
        ctx2_nxt.same = 1'b1;
        for (int i = 0; i < LANES; i++) begin
          d    = 33'($signed(a1_r[i])) - 33'($signed(b1_r[i]));
          dabs = d[32] ? 33'(-d) : 33'(d);
          if (!(dabs < {17'd0, tol_r})) begin
            ctx2_nxt.same = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (mode1_r == MODE_SCALE) begin
        op2[i] = $signed(f1_r);
      end else if (mode1_r == MODE_MAG || mode1_r == MODE_NORM) begin
        op2[i] = $signed(a1_r[i]);
      end else begin
        op2[i] = $signed(b1_r[i]);
      end
      p2_nxt[i] = $signed(a1_r[i]) * op2[i];
    end
    cx2_nxt[0] = $signed(a1_r[1]) * $signed(b1_r[2]);
    cx2_nxt[1] = $signed(a1_r[2]) * $signed(b1_r[1]);
    cx2_nxt[2] = $signed(a1_r[2]) * $signed(b1_r[0]);
    cx2_nxt[3] = $signed(a1_r[0]) * $signed(b1_r[2]);
    cx2_nxt[4] = $signed(a1_r[0]) * $signed(b1_r[1]);
    cx2_nxt[5] = $signed(a1_r[1]) * $signed(b1_r[0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx2_r <= ctx2_nxt;
      p2_r   <= p2_nxt;
      cx2_r  <= cx2_nxt;
      b2_r   <= b1_r;
    end
  end

  // ---------------- stage 3: sums of products, floor to q16.16
  ctx_t                   ctx3_nxt, ctx3_r;
  logic                   v3_r;
  logic [63:0]            sq3_nxt, sq3_r;
  logic                   big3_nxt, big3_r;
  logic [LANES-1:0][31:0] b3_r;

  always_comb begin
    logic [32:0]        tmp;
    logic signed [65:0] acc;
    logic signed [65:0] sqs;
    ctx3_nxt = ctx2_r;
    tmp = '0;
    acc = 66'(p2_r[0]) + 66'(p2_r[1]) + 66'(p2_r[2]);
    // squares are never negative, so bit 64 is the wrap of a 64-bit sum
    sqs = 66'(p2_r[0]) + 66'(p2_r[1]) + 66'(p2_r[2]) + 66'(p2_r[3]);
    sq3_nxt  = sqs[63:0];
    big3_nxt = sqs[64];
    case (ctx2_r.mode)
      MODE_SCALE: begin
        for (int i = 0; i < LANES; i++) begin
          tmp = clip_q(66'(p2_r[i] >>> 16));
          ctx3_nxt.r[i] = tmp[31:0];
          ctx3_nxt.sat  = ctx3_nxt.sat | tmp[32];
        end
      end
      MODE_DOT, MODE_REFL: begin
        tmp = clip_q(acc >>> 16);
        ctx3_nxt.scal = tmp[31:0];
        ctx3_nxt.sat  = tmp[32];
      end
      MODE_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          tmp = clip_q((66'(cx2_r[2*i]) - 66'(cx2_r[2*i+1])) >>> 16);
          ctx3_nxt.r[i] = tmp[31:0];
          ctx3_nxt.sat  = ctx3_nxt.sat | tmp[32];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx3_r <= ctx3_nxt;
      sq3_r  <= sq3_nxt;
      big3_r <= big3_nxt;
      b3_r   <= b2_r;
    end
  end

  // ---------------- stage 4: reflect product b * dot
  ctx_t               ctx4_r;
  logic               v4_r;
  logic signed [63:0] rp4_nxt [LANES];
  logic signed [63:0] rp4_r [LANES];
  logic [63:0]        sq4_r;
  logic               big4_r;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      rp4_nxt[i] = $signed(b3_r[i]) * $signed(ctx3_r.scal);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx4_r <= ctx3_r;
      rp4_r  <= rp4_nxt;
      sq4_r  <= sq3_r;
      big4_r <= big3_r;
    end
  end

  // ---------------- stage 5: reflect subtract, then square root steps
  ctx_t              ctx5_nxt;
  ctx_t              sctx_r  [SQRT_STEPS+1];
  logic              sv_r    [SQRT_STEPS+1];
  logic [63:0]       srem_r  [SQRT_STEPS+1];
  logic [ROOT_W-1:0] sroot_r [SQRT_STEPS+1];
  logic              sbig_r  [SQRT_STEPS+1];

  always_comb begin
    logic [32:0] tmp;
    ctx5_nxt = ctx4_r;
    tmp = '0;
    if (ctx4_r.mode == MODE_REFL) begin
      for (int i = 0; i < LANES; i++) begin
        // 2*b*d / 2^16 is b*d / 2^15, floored
        tmp = clip_q(66'($signed(ctx4_r.a[i])) - 66'(rp4_r[i] >>> 15));
        ctx5_nxt.r[i] = tmp[31:0];
        ctx5_nxt.sat  = ctx5_nxt.sat | tmp[32];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else if (adv) begin
      sv_r[0] <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sctx_r[0]  <= ctx5_nxt;
      srem_r[0]  <= sq4_r;
      sroot_r[0] <= '0;
      sbig_r[0]  <= big4_r;
    end
  end

  // one root bit per stage, most significant first; remainder = s - root^2
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam int unsigned BIT = SQRT_STEPS - 1 - k;
    logic [65:0] delta, remx;

    assign delta = (66'(sroot_r[k]) << (BIT + 1)) + (66'd1 << (2 * BIT));
    assign remx  = 66'(srem_r[k]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k+1] <= 1'b0;
      end else if (adv) begin
        sv_r[k+1] <= sv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sctx_r[k+1] <= sctx_r[k];
        sbig_r[k+1] <= sbig_r[k];
        if (remx >= delta) begin
          srem_r[k+1]  <= 64'(remx - delta);
          sroot_r[k+1] <= sroot_r[k] | (ROOT_W'(1) << BIT);
        end else begin
          srem_r[k+1]  <= srem_r[k];
          sroot_r[k+1] <= sroot_r[k];
        end
      end
    end
  end

  // ---------------- setup stage: magnitude result and divider operands
  ctx_t                      dctx_nxt;
  logic [DEN_W-1:0]          dden_nxt;
  logic [LANES-1:0][NUM_W-1:0] dnum_nxt;
  logic [LANES-1:0]          dneg_nxt;

  ctx_t                        dctx_r [DIV_STEPS+1];
  logic                        dv_r   [DIV_STEPS+1];
  logic [DEN_W-1:0]            dden_r [DIV_STEPS+1];
  logic [LANES-1:0][NUM_W-1:0] dnum_r [DIV_STEPS+1];
  logic [LANES-1:0][REM_W-1:0] drem_r [DIV_STEPS+1];
  logic [LANES-1:0][NUM_W-1:0] dq_r   [DIV_STEPS+1];
  logic [LANES-1:0]            dneg_r [DIV_STEPS+1];

  always_comb begin
    logic [32:0] tmp;
    logic [32:0] t;
    logic [31:0] aabs;
    logic [31:0] fv;
    dctx_nxt = sctx_r[SQRT_STEPS];
    fv  = dctx_nxt.f;
    t   = sbig_r[SQRT_STEPS] ? {1'b1, 32'd0} : {1'b0, sroot_r[SQRT_STEPS]};
    tmp = '0;
    dden_nxt = t;
    case (dctx_nxt.mode)
      MODE_MAG: begin
        tmp = clip_q(66'(t));
        dctx_nxt.scal = tmp[31:0];
        dctx_nxt.sat  = tmp[32];
      end
      MODE_NORM: begin
        tmp = clip_q(66'(t));
        dctx_nxt.scal = tmp[31:0];
        dctx_nxt.sat  = tmp[32];
        dctx_nxt.zdiv = (t == '0);
      end
      MODE_DIV: begin
        dden_nxt = fv[31] ? (~{1'b1, fv} + 33'd1) : {1'b0, fv};
      end
      default: begin
      end
    endcase
    for (int i = 0; i < LANES; i++) begin
      aabs = dctx_nxt.a[i][31] ? (~dctx_nxt.a[i] + 32'd1) : dctx_nxt.a[i];
      dnum_nxt[i] = {aabs, 16'd0};
      dneg_nxt[i] = dctx_nxt.a[i][31] ^ ((dctx_nxt.mode == MODE_DIV) & fv[31]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (adv) begin
      dv_r[0] <= sv_r[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dctx_r[0] <= dctx_nxt;
      dden_r[0] <= dden_nxt;
      dnum_r[0] <= dnum_nxt;
      drem_r[0] <= '0;
      dq_r[0]   <= '0;
      dneg_r[0] <= dneg_nxt;
    end
  end

  // restoring divide on magnitudes, one quotient bit per stage in each lane
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int unsigned BIT = DIV_STEPS - 1 - k;
    logic [LANES-1:0][REM_W-1:0] remn;
    logic [LANES-1:0]            take;

    always_comb begin
      for (int i = 0; i < LANES; i++) begin
        remn[i] = {drem_r[k][i][REM_W-2:0], dnum_r[k][i][BIT]};
        take[i] = (remn[i] >= REM_W'(dden_r[k]));
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_r[k+1] <= dv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dctx_r[k+1] <= dctx_r[k];
        dden_r[k+1] <= dden_r[k];
        dnum_r[k+1] <= dnum_r[k];
        dneg_r[k+1] <= dneg_r[k];
        for (int i = 0; i < LANES; i++) begin
          if (take[i]) begin
            drem_r[k+1][i]      <= remn[i] - REM_W'(dden_r[k]);
            dq_r[k+1][i]        <= dq_r[k][i] | (NUM_W'(1) << BIT);
          end else begin
            drem_r[k+1][i]      <= remn[i];
            dq_r[k+1][i]        <= dq_r[k][i];
          end
        end
      end
    end
  end

  // ---------------- output register: sign, clip, zero-divisor handling
  ctx_t         fctx;
  logic [159:0] out_tdata_nxt;
  logic [4:0]   out_tuser_nxt;
  logic [159:0] out_tdata_r;
  logic [4:0]   out_tuser_r;

  always_comb begin
    logic [NUM_W-1:0] q;
    logic             dz;
    fctx = dctx_r[DIV_STEPS];
    dz   = (dden_r[DIV_STEPS] == '0);
    q    = '0;
    if (fctx.mode == MODE_DIV || fctx.mode == MODE_NORM) begin
      if (dz) begin
        fctx.zdiv = 1'b1;
      end
      for (int i = 0; i < LANES; i++) begin
        q = dq_r[DIV_STEPS][i];
        if (dz) begin
          // zero divisor: sign of the numerator picks the rail
          if (dnum_r[DIV_STEPS][i] == '0) begin
            fctx.r[i] = '0;
          end else if (dneg_r[DIV_STEPS][i]) begin
            fctx.r[i] = Q_MIN;
          end else begin
            fctx.r[i] = Q_MAX;
          end
        end else if (!dneg_r[DIV_STEPS][i]) begin
          if (q > NUM_W'(Q_MAX)) begin
            fctx.r[i] = Q_MAX;
            fctx.sat  = 1'b1;
          end else begin
            fctx.r[i] = q[31:0];
          end
        end else begin
          if (q > NUM_W'(Q_MIN)) begin
            fctx.r[i] = Q_MIN;
            fctx.sat  = 1'b1;
          end else begin
            fctx.r[i] = ~q[31:0] + 32'd1;
          end
        end
      end
    end
    out_tdata_nxt = {fctx.scal, fctx.r[3], fctx.r[2], fctx.r[1], fctx.r[0]};
    out_tuser_nxt = {fctx.sat, fctx.zdiv, fctx.a_vector, fctx.a_point, fctx.same};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= dv_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= out_tuser_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // ---------------- checks
  `V4A_ASSERT_NOW(a_point_xor_vector, !(out_tvalid && out_tuser[1] && out_tuser[2]), "point and vector both set")
  `V4A_ASSERT_IMP(a_same_zero_data, out_tvalid && out_tuser[0], out_tdata == '0, "equal result carries data")
  `V4A_ASSERT_IMP(a_zdiv_no_sat, out_tvalid && out_tuser[3], !out_tuser[4], "zero divide also flagged saturated")
  `V4A_ASSERT_NXT(a_stall_keeps_item, !adv && dv_r[DIV_STEPS], dv_r[DIV_STEPS], "item lost during stall")

endmodule
